FILE: hw/rtl/binary_to_decimal_ascii_unit_defines.svh
// Assertion macros shared by the binary to decimal ASCII unit.
// Needs no other file; define ASSERT_OFF to compile the checks out.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define BDAU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdau check failed");
`define BDAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdau check failed");
`else
`define BDAU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BDAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/bdau_pkg.sv
// Shared types, constants and the double dabble step for the converter.
// Used by every module of the binary to decimal ASCII unit; depends on nothing.
package bdau_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int CNT_W      = 5;
    localparam int SHIFT_W    = 6;
    localparam int CHAR_W     = 6;

    localparam logic [CNT_W-1:0]   DIGITS_MAX = CNT_W'(NUM_DIGITS);
    localparam logic [SHIFT_W-1:0] SHIFT_LAST = SHIFT_W'(VALUE_W - 1);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;

    typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        bcd_t             bcd;
        logic [CNT_W-1:0] ndig;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SHIFT,
        FR_PUSH
    } front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    // One double dabble step: correct every digit of five or more, then shift
    // the whole BCD word left by one with the new binary bit at the bottom.
    function automatic bcd_t dabble_step(bcd_t bcd, logic in_bit);
        bcd_t adj;
        bcd_t res;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
        end
        res[0] = {adj[0][2:0], in_bit};
        for (int i = 1; i < NUM_DIGITS; i++) begin
            res[i] = {adj[i][2:0], adj[i-1][3]};
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/binary_to_decimal_ascii_unit.sv
// Binary to decimal ASCII unit. A 64-bit unsigned word is taken when start is
// high and busy is low; busy then stays high while the front end runs one double
// dabble shift per cycle over all 64 bits and hands the result to a two-entry
// queue, so no new word is taken until that result is in the queue, after any
// wait for a free queue slot. The back end drains the queue on its own, sending
// one ASCII digit per cycle with digit_valid high, most significant first and
// without leading zeros, after first loading the word; last marks the final
// digit. A word gives 1 to 20 digits, and the receiver must take each one in
// the cycle that it appears. Depends on bdau_pkg and the assertion macro header.
`include "binary_to_decimal_ascii_unit_defines.svh"

module binary_to_decimal_ascii_unit
    import bdau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [VALUE_W-1:0] value,
    output logic              busy,
    output logic              digit_valid,
    output logic [CHAR_W-1:0] digit_char,
    output logic              last
);

    push_t       push_w;
    queue_stat_t qstat_w;
    entry_t      head_w;
    logic        pop_w;

    bdau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value    (value),
        .qstat    (qstat_w),
        .busy     (busy),
        .push_out (push_w)
    );

    bdau_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push_w),
        .pop     (pop_w),
        .qstat   (qstat_w),
        .head    (head_w)
    );

    bdau_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat_w),
        .head        (head_w),
        .pop         (pop_w),
        .digit_valid (digit_valid),
        .digit_char  (digit_char),
        .last        (last)
    );

    `BDAU_ASSERT_IMPLY(a_char_range, clk, rst_n, digit_valid, (digit_char >= 6'd48) && (digit_char <= 6'd57))
    `BDAU_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
    `BDAU_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push_w.push, !qstat_w.full)
    `BDAU_ASSERT_IMPLY(a_pop_when_idle, clk, rst_n, pop_w, !digit_valid && !qstat_w.empty)

endmodule

FILE: hw/rtl/bdau_front.sv
// Front end: accepts a word, runs the bit-serial double dabble over all 64
// bits, tracks the digit count and pushes the result. Depends on bdau_pkg.
module bdau_front
    import bdau_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [VALUE_W-1:0]  value,
    input  queue_stat_t         qstat,
    output logic                busy,
    output push_t               push_out
);

    front_state_t        state_reg, state_next;
    logic [SHIFT_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    bcd_t                bcd_reg, bcd_next;
    logic [CNT_W-1:0]    ndig_reg, ndig_next;
    bcd_t                bcd_step;
    logic                grow;

    assign bcd_step = dabble_step(bcd_reg, bin_reg[VALUE_W-1]);

    // The digit count can rise by at most one per doubling, so only the digit
    // just above the current top needs a look.
    always_comb
    begin
        grow = 1'b0;
        if (ndig_reg < DIGITS_MAX)
        begin
            grow = (bcd_step[ndig_reg] != 4'd0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (start)
                begin
                    state_next = FR_SHIFT;
                end
            end
            FR_SHIFT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (!qstat.full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        ndig_next = ndig_reg;
        busy      = 1'b1;
        push_out.push = 1'b0;
        push_out.entry.bcd  = bcd_reg;
        // A zero value still shows one digit.
        push_out.entry.ndig = (ndig_reg == '0) ? CNT_W'(1) : ndig_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cnt_next  = SHIFT_LAST;
                    bin_next  = value;
                    bcd_next  = '0;
                    ndig_next = '0;
                end
            end
            FR_SHIFT:
            begin
                cnt_next  = cnt_reg - SHIFT_W'(1);
                bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
                bcd_next  = bcd_step;
                ndig_next = ndig_reg + CNT_W'(grow);
            end
            FR_PUSH:
            begin
                push_out.push = !qstat.full;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            cnt_reg   <= '0;
            ndig_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ndig_reg  <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

FILE: hw/rtl/bdau_queue.sv
// Two-entry queue of converted words between the front and back ends.
// Depends on bdau_pkg.
module bdau_queue
    import bdau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push_in,
    input  logic        pop,
    output queue_stat_t qstat,
    output entry_t      head
);

    entry_t       mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   fill_reg, fill_next;
    logic         do_push;
    logic         do_pop;

    assign qstat.full  = (fill_reg == 2'd2);
    assign qstat.empty = (fill_reg == 2'd0);
    assign do_push     = push_in.push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_in.entry;
        end
    end

endmodule

FILE: hw/rtl/bdau_back.sv
// Back end: takes a converted word from the queue and sends its digits out
// as ASCII, most significant first, one per cycle. Depends on bdau_pkg.
module bdau_back
    import bdau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_stat_t       qstat,
    input  entry_t            head,
    output logic              pop,
    output logic              digit_valid,
    output logic [CHAR_W-1:0] digit_char,
    output logic              last
);

    back_state_t       state_reg, state_next;
    bcd_t              bcd_reg, bcd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  pos;

    assign pos = rem_reg - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        digit_valid = 1'b0;
        bcd_next    = bcd_reg;
        rem_next    = rem_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop      = 1'b1;
                    bcd_next = head.bcd;
                    rem_next = head.ndig;
                end
            end
            BK_EMIT:
            begin
                digit_valid = 1'b1;
                rem_next    = pos;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // The digit count never exceeds twenty, so pos lands inside the word whenever a digit is sent.
    assign digit_char = ASCII_ZERO + {2'b00, bcd_reg[pos]};
    assign last       = (rem_reg == CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

endmodule

FILE: dv/binary_to_decimal_ascii_unit_tb.sv
// Self-checking testbench for binary_to_decimal_ascii_unit: drives 64-bit words
// and checks every ASCII digit and end marker against a built-in predictor.
// Depends on bdau_pkg and the unit's RTL.
module binary_to_decimal_ascii_unit_tb;
    import bdau_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } digit_word_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [VALUE_W-1:0] value = '0;
    logic               busy;
    logic               digit_valid;
    logic [CHAR_W-1:0]  digit_char;
    logic               last;

    digit_word_t expected_digits[$];
    int          errors      = 0;
    int          cycle_count = 0;
    bit          no_idle     = 1'b0;

    binary_to_decimal_ascii_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .value       (value),
        .busy        (busy),
        .digit_valid (digit_valid),
        .digit_char  (digit_char),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Expands one word into its decimal digits, most significant first.
    function automatic void push_decimal_digits(logic [VALUE_W-1:0] v);
        logic [3:0]  rev[NUM_DIGITS];
        int          n;
        digit_word_t w;
        n = 0;
        do
        begin
            rev[n] = 4'(v % 10);
            v      = v / 10;
            n++;
        end
        while (v != 0);
        for (int k = n - 1; k >= 0; k--)
        begin
            w.code = ASCII_ZERO + CHAR_W'(rev[k]);
            w.last = (k == 0);
            expected_digits.push_back(w);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Builds a random value with exactly n decimal digits.
    function automatic logic [VALUE_W-1:0] random_with_digits(int n);
        logic [VALUE_W-1:0] v;
        if (n >= NUM_DIGITS)
        begin
            do
                v = random_word();
            while (v < 64'd10000000000000000000);
            return v;
        end
        v = VALUE_W'($urandom_range(1, 9));
        for (int i = 1; i < n; i++)
            v = v * 10 + VALUE_W'($urandom_range(0, 9));
        return v;
    endfunction

    // Called right after a rising edge; returns right after the edge that took the word.
    task automatic send_word(logic [VALUE_W-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            start <= 1'b0;
            value <= random_word();
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        push_decimal_digits(v);
    endtask

    always @(posedge clk)
    begin
        digit_word_t w;
        if (rst_n && digit_valid)
        begin
            if (expected_digits.size() == 0)
            begin
                $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                         $time, digit_char, last);
                errors++;
            end
            else
            begin
                w = expected_digits.pop_front();
                if (digit_char !== w.code)
                begin
                    $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                             $time, w.code, digit_char);
                    errors++;
                end
                if (last !== w.last)
                begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, w.last, last);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed_edges();
        logic [VALUE_W-1:0] vals[$];
        vals = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd101,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'd10000000000000000000, 64'd9999999999999999999,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'd1234567890, 64'hFFFF_FFFF, 64'h1_0000_0000,
                 64'd1000000000000000000, 64'd0, 64'd5, 64'd18446744073709551610};
        foreach (vals[i])
            send_word(vals[i]);
    endtask

    task automatic test_random_full_range(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                no_idle = !no_idle;
            send_word(random_word());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_digit_counts(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 9) == 0)
                send_word('0);
            else
                send_word(random_with_digits($urandom_range(1, NUM_DIGITS)));
        end
        no_idle = 1'b0;
    endtask

    // Short values with no gaps keep the shifter busy with back-to-back words.
    task automatic test_back_to_back_short(int count);
        no_idle = 1'b1;
        for (int i = 0; i < count; i++)
            send_word(random_with_digits($urandom_range(1, 3)));
        no_idle = 1'b0;
    endtask

    task automatic test_mixed_lengths(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 2 == 0)
                send_word(random_with_digits(NUM_DIGITS));
            else
                send_word(VALUE_W'($urandom_range(0, 9)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_random_full_range(100);
        test_random_digit_counts(100);
        test_back_to_back_short(48);
        test_mixed_lengths(40);
        start <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
